// ===== rtl/core/gdce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdce_pkg
// Shared widths, codes and the command / status bundles between the
// controller and the datapath of the depth-first search engine.
// ----------------------------------------------------------------------------
package gdce_pkg;

	localparam int NODE_W   = 6;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD   = 2'd0,
		FUNC_WALK  = 2'd1,
		FUNC_CYCLE = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	// commands from the controller
	typedef struct packed {
		logic    ld_item;
		logic    grow;
		logic    add_second;
		logic    add_rd;
		logic    add_wr;
		logic    add_link;
		logic    clr_marks;
		logic    root_push;
		logic    root_scan;
		logic    load_head;
		logic    edge_rd;
		logic    take;
		logic    push;
		logic    pop;
		logic    pop_load;
		logic    scan_inc;
		logic    emit_node;
		logic    flush;
		logic    emit_single;
		logic    set_res;
		status_t res_status;
		logic    res_cyc;
	} cmd_t;

	// status back to the controller
	typedef struct packed {
		func_t func;
		logic  mode;
		logic  add_oob;
		logic  add_full;
		logic  start_bad;
		logic  cur_null;
		logic  w_visited;
		logic  cyc_hit;
		logic  depth_one;
		logic  scan_done;
		logic  scan_visited;
		logic  out_free;
		logic  pend_valid;
	} sts_t;

endpackage

// ===== rtl/core/gdce_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdce_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module gdce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/gdce_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdce_dp
// Datapath: edge table, list head / tail memories, walk stack, marks,
// counters and the result registers.
// ----------------------------------------------------------------------------
module gdce_dp #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gdce_pkg::cmd_t                    cmd,
	output gdce_pkg::sts_t                    sts,
	input  logic [gdce_pkg::FUNC_W-1:0]       func,
	input  logic [gdce_pkg::NODE_W-1:0]       first_node,
	input  logic [gdce_pkg::NODE_W-1:0]       second_node,
	input  logic                              cfg_valid,
	input  logic                              cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [gdce_pkg::STATUS_W-1:0]     status,
	output logic [gdce_pkg::NODE_W-1:0]       visited_node,
	output logic                              last_of_run,
	output logic                              cycle_found,
	output logic                              is_tree_flag,
	output logic                              is_dag_flag,
	output logic [gdce_pkg::COUNT_W-1:0]      node_total
);

	localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EIW = $clog2(MAX_EDGES);
	localparam int LW  = EIW + 1;
	localparam int FW  = 2 * gdce_pkg::NODE_W + 1 + LW;
	localparam int NB  = gdce_pkg::NODE_W;
	localparam int CW  = gdce_pkg::COUNT_W;

	// item and configuration
	gdce_pkg::func_t  func_q;
	logic [NB-1:0]    a_q;
	logic [NB-1:0]    b_q;
	logic             mode_q;

	// graph bookkeeping
	logic [EIW:0]     edges_q;
	logic [CW-1:0]    nodes_q;
	logic [MAX_NODES-1:0] list_vld_q;
	logic             tail_vld_q;
	logic             head_vld_q;

	// walk state
	logic [MAX_NODES-1:0] visited_q;
	logic [MAX_NODES-1:0] onstk_q;
	logic [NW:0]      depth_q;
	logic [NB-1:0]    top_node_q;
	logic             top_hp_q;
	logic [NB-1:0]    top_par_q;
	logic [LW-1:0]    top_cur_q;
	logic [CW-1:0]    scan_q;

	// result path
	logic             pend_valid_q;
	logic [NB-1:0]    pend_node_q;
	gdce_pkg::status_t res_status_q;
	logic             res_cyc_q;
	logic             out_valid_q;
	logic [gdce_pkg::STATUS_W-1:0] out_status_q;
	logic [NB-1:0]    out_node_q;
	logic             out_last_q;
	logic             out_cyc_q;
	logic             out_tree_q;
	logic             out_dag_q;
	logic [CW-1:0]    out_total_q;

	// memory ports
	logic [NB-1:0]    tgt_rd;
	logic [LW-1:0]    link_rd;
	logic [EIW-1:0]   head_rd;
	logic [EIW-1:0]   tail_rd;
	logic [FW-1:0]    stk_rd;
	logic             link_we;
	logic [EIW-1:0]   link_waddr;
	logic [LW-1:0]    link_wdata;

	logic [NB-1:0]    add_u;
	logic [NB-1:0]    add_v;
	logic [EIW-1:0]   new_idx;
	logic [NB-1:0]    root_node;
	logic [NB-1:0]    push_node;
	logic [NB-1:0]    w;
	logic [CW-1:0]    hi_node;
	logic [EIW+1:0]   need_sum;
	logic             out_free;

	// node selection
	assign add_u     = cmd.add_second ? b_q : a_q;
	assign add_v     = cmd.add_second ? a_q : b_q;
	assign new_idx   = edges_q[EIW-1:0];
	assign root_node = cmd.root_scan ? scan_q[NB-1:0] : a_q;
	assign w         = tgt_rd;
	assign push_node = cmd.root_push ? root_node : w;
	assign hi_node   = ((a_q > b_q) ? {1'b0, a_q} : {1'b0, b_q}) + CW'(1);
	assign need_sum  = {1'b0, edges_q} + (mode_q ? (EIW+2)'(1) : (EIW+2)'(2));
	assign out_free  = !out_valid_q || out_ready;

	// status to the controller
	always_comb begin
		sts.func         = func_q;
		sts.mode         = mode_q;
		sts.add_oob      = ({1'b0, a_q} >= CW'(MAX_NODES)) ||
		                   ({1'b0, b_q} >= CW'(MAX_NODES));
		sts.add_full     = need_sum > (EIW+2)'(MAX_EDGES);
		sts.start_bad    = {1'b0, a_q} >= nodes_q;
		sts.cur_null     = !top_cur_q[LW-1];
		sts.w_visited    = visited_q[w[NW-1:0]];
		sts.cyc_hit      = mode_q ? onstk_q[w[NW-1:0]] :
		                   (visited_q[w[NW-1:0]] && !(top_hp_q && top_par_q == w));
		sts.depth_one    = depth_q == (NW+1)'(1);
		sts.scan_done    = scan_q >= nodes_q;
		sts.scan_visited = visited_q[scan_q[NW-1:0]];
		sts.out_free     = out_free;
		sts.pend_valid   = pend_valid_q;
	end

	// edge link writes: null on append, then chain from old tail
	always_comb begin
		link_we    = 1'b0;
		link_waddr = new_idx;
		link_wdata = '0;
		if (cmd.add_wr) begin
			link_we = 1'b1;
		end else if (cmd.add_link && tail_vld_q) begin
			link_we    = 1'b1;
			link_waddr = tail_rd;
			link_wdata = {1'b1, new_idx};
		end
	end

	gdce_ram #(.WIDTH(NB), .DEPTH(MAX_EDGES)) u_tgt (
		.clk(clk), .we(cmd.add_wr), .waddr(new_idx), .wdata(add_v),
		.re(cmd.edge_rd), .raddr(top_cur_q[EIW-1:0]), .rdata(tgt_rd)
	);

	gdce_ram #(.WIDTH(LW), .DEPTH(MAX_EDGES)) u_link (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.re(cmd.edge_rd), .raddr(top_cur_q[EIW-1:0]), .rdata(link_rd)
	);

	gdce_ram #(.WIDTH(EIW), .DEPTH(MAX_NODES)) u_head (
		.clk(clk), .we(cmd.add_link && !tail_vld_q), .waddr(add_u[NW-1:0]),
		.wdata(new_idx), .re(cmd.root_push || cmd.push),
		.raddr(push_node[NW-1:0]), .rdata(head_rd)
	);

	gdce_ram #(.WIDTH(EIW), .DEPTH(MAX_NODES)) u_tail (
		.clk(clk), .we(cmd.add_link), .waddr(add_u[NW-1:0]), .wdata(new_idx),
		.re(cmd.add_rd), .raddr(add_u[NW-1:0]), .rdata(tail_rd)
	);

	gdce_ram #(.WIDTH(FW), .DEPTH(MAX_NODES)) u_stack (
		.clk(clk), .we(cmd.push), .waddr(NW'(depth_q - (NW+1)'(1))),
		.wdata({top_node_q, top_hp_q, top_par_q, link_rd}),
		.re(cmd.pop && !sts.depth_one), .raddr(NW'(depth_q - (NW+1)'(2))),
		.rdata(stk_rd)
	);

	// item capture and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
			func_q <= gdce_pkg::FUNC_NONE;
		end else begin
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (cmd.ld_item) begin
				func_q <= gdce_pkg::func_t'(func);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			a_q <= first_node;
			b_q <= second_node;
		end
	end

	// edge count, node count and list valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges_q    <= '0;
			nodes_q    <= '0;
			list_vld_q <= '0;
		end else begin
			if (cmd.grow && hi_node > nodes_q) begin
				nodes_q <= hi_node;
			end
			if (cmd.add_link) begin
				edges_q <= edges_q + (EIW+1)'(1);
				list_vld_q[add_u[NW-1:0]] <= 1'b1;
			end
		end
	end

	// valid flags captured next to the list reads
	always_ff @(posedge clk) begin
		if (cmd.add_rd) begin
			tail_vld_q <= list_vld_q[add_u[NW-1:0]];
		end
		if (cmd.root_push || cmd.push) begin
			head_vld_q <= list_vld_q[push_node[NW-1:0]];
		end
	end

	// visit marks and stack depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			onstk_q   <= '0;
			depth_q   <= '0;
			scan_q    <= '0;
		end else begin
			if (cmd.clr_marks) begin
				visited_q <= '0;
				onstk_q   <= '0;
				scan_q    <= '0;
			end
			if (cmd.root_push || cmd.push) begin
				visited_q[push_node[NW-1:0]] <= 1'b1;
				onstk_q[push_node[NW-1:0]]   <= 1'b1;
			end
			if (cmd.pop) begin
				onstk_q[top_node_q[NW-1:0]] <= 1'b0;
			end
			if (cmd.scan_inc) begin
				scan_q <= scan_q + CW'(1);
			end
			priority if (cmd.root_push) begin
				depth_q <= (NW+1)'(1);
			end else if (cmd.push) begin
				depth_q <= depth_q + (NW+1)'(1);
			end else if (cmd.pop) begin
				depth_q <= depth_q - (NW+1)'(1);
			end
		end
	end

	// top-of-stack frame
	always_ff @(posedge clk) begin
		priority if (cmd.root_push) begin
			top_node_q <= root_node;
			top_hp_q   <= 1'b0;
			top_par_q  <= '0;
		end else if (cmd.push) begin
			top_node_q <= w;
			top_hp_q   <= 1'b1;
			top_par_q  <= top_node_q;
		end else if (cmd.take) begin
			top_cur_q <= link_rd;
		end else if (cmd.load_head) begin
			top_cur_q <= {head_vld_q, head_rd};
		end else if (cmd.pop_load) begin
			{top_node_q, top_hp_q, top_par_q, top_cur_q} <= stk_rd;
		end
	end

	// pending walk node and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.emit_node) begin
				pend_valid_q <= 1'b1;
				if (pend_valid_q) begin
					out_valid_q <= 1'b1;
				end
			end
			if (cmd.flush) begin
				pend_valid_q <= 1'b0;
				out_valid_q  <= 1'b1;
			end
			if (cmd.emit_single) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_status_q <= cmd.res_status;
			res_cyc_q    <= cmd.res_cyc;
		end
		if (cmd.emit_node) begin
			pend_node_q <= push_node;
		end
		if ((cmd.emit_node && pend_valid_q) || cmd.flush) begin
			out_status_q <= gdce_pkg::ST_OK;
			out_node_q   <= pend_node_q;
			out_last_q   <= cmd.flush;
			out_cyc_q    <= 1'b0;
			out_tree_q   <= 1'b0;
			out_dag_q    <= 1'b0;
			out_total_q  <= nodes_q;
		end else if (cmd.emit_single) begin
			out_status_q <= res_status_q;
			out_node_q   <= '0;
			out_last_q   <= 1'b1;
			out_cyc_q    <= res_cyc_q;
			out_tree_q   <= (func_q == gdce_pkg::FUNC_CYCLE) && !mode_q && !res_cyc_q;
			out_dag_q    <= (func_q == gdce_pkg::FUNC_CYCLE) && mode_q && !res_cyc_q;
			out_total_q  <= nodes_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign visited_node = out_node_q;
	assign last_of_run  = out_last_q;
	assign cycle_found  = out_cyc_q;
	assign is_tree_flag = out_tree_q;
	assign is_dag_flag  = out_dag_q;
	assign node_total   = out_total_q;

	// stack, table and node count stay within their bounds
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= (NW+1)'(MAX_NODES))
		else $error("walk stack deeper than node limit");

	a_edges_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edges_q <= (EIW+1)'(MAX_EDGES))
		else $error("edge count beyond table size");

	a_nodes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_q <= CW'(MAX_NODES))
		else $error("node count beyond node limit");

	// a non-final walk beat always has a later node waiting behind it
	a_pend_behind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_last_q |-> pend_valid_q)
		else $error("non-final beat with nothing pending");

endmodule

// ===== rtl/core/gdce_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdce_ctrl
// Controller: sequences edge appends, the depth-first walk and the cycle
// check over the datapath.
// ----------------------------------------------------------------------------
module gdce_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  gdce_pkg::sts_t sts,
	output gdce_pkg::cmd_t cmd
);

	typedef enum logic [11:0] {
		S_IDLE     = 12'b000000000001,
		S_DISP     = 12'b000000000010,
		S_ADD_RD   = 12'b000000000100,
		S_ADD_WR   = 12'b000000001000,
		S_ADD_LINK = 12'b000000010000,
		S_EMIT1    = 12'b000000100000,
		S_LD_HEAD  = 12'b000001000000,
		S_W_EDGE   = 12'b000010000000,
		S_W_TAKE   = 12'b000100000000,
		S_POP_LD   = 12'b001000000000,
		S_SCAN     = 12'b010000000000,
		S_FLUSH    = 12'b100000000000
	} state_t;

	state_t state_q, state_d;
	logic   second_q, second_d;
	logic   is_walk;

	assign in_ready = (state_q == S_IDLE);
	assign is_walk  = (sts.func == gdce_pkg::FUNC_WALK);

	// next state and commands
	always_comb begin
		state_d = state_q;
		second_d = second_q;
		cmd = '0;
		cmd.add_second = second_q;
		cmd.res_status = gdce_pkg::ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.ld_item = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.func)
					gdce_pkg::FUNC_ADD: begin
						cmd.set_res = 1'b1;
						second_d = 1'b0;
						priority if (sts.add_oob) begin
							cmd.res_status = gdce_pkg::ST_RANGE;
							state_d = S_EMIT1;
						end else if (sts.add_full) begin
							cmd.res_status = gdce_pkg::ST_FULL;
							state_d = S_EMIT1;
						end else begin
							cmd.grow = 1'b1;
							state_d = S_ADD_RD;
						end
					end
					gdce_pkg::FUNC_WALK: begin
						if (sts.start_bad) begin
							cmd.set_res = 1'b1;
							cmd.res_status = gdce_pkg::ST_RANGE;
							state_d = S_EMIT1;
						end else begin
							cmd.clr_marks = 1'b1;
							cmd.root_push = 1'b1;
							cmd.emit_node = 1'b1;
							state_d = S_LD_HEAD;
						end
					end
					gdce_pkg::FUNC_CYCLE: begin
						cmd.clr_marks = 1'b1;
						state_d = S_SCAN;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_ADD_RD: begin
				cmd.add_rd = 1'b1;
				state_d = S_ADD_WR;
			end
			S_ADD_WR: begin
				cmd.add_wr = 1'b1;
				state_d = S_ADD_LINK;
			end
			S_ADD_LINK: begin
				cmd.add_link = 1'b1;
				if (!sts.mode && !second_q) begin
					second_d = 1'b1;
					state_d = S_ADD_RD;
				end else begin
					state_d = S_EMIT1;
				end
			end
			S_EMIT1: begin
				if (sts.out_free) begin
					cmd.emit_single = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_LD_HEAD: begin
				cmd.load_head = 1'b1;
				state_d = S_W_EDGE;
			end
			S_W_EDGE: begin
				if (sts.cur_null) begin
					cmd.pop = 1'b1;
					priority if (!sts.depth_one) begin
						state_d = S_POP_LD;
					end else if (is_walk) begin
						state_d = S_FLUSH;
					end else begin
						state_d = S_SCAN;
					end
				end else begin
					cmd.edge_rd = 1'b1;
					state_d = S_W_TAKE;
				end
			end
			S_W_TAKE: begin
				priority if (is_walk) begin
					if (sts.w_visited) begin
						cmd.take = 1'b1;
						state_d = S_W_EDGE;
					end else if (sts.out_free || !sts.pend_valid) begin
						cmd.push = 1'b1;
						cmd.emit_node = 1'b1;
						state_d = S_LD_HEAD;
					end
				end else if (sts.cyc_hit) begin
					cmd.set_res = 1'b1;
					cmd.res_cyc = 1'b1;
					state_d = S_EMIT1;
				end else if (!sts.w_visited) begin
					cmd.push = 1'b1;
					state_d = S_LD_HEAD;
				end else begin
					cmd.take = 1'b1;
					state_d = S_W_EDGE;
				end
			end
			S_POP_LD: begin
				cmd.pop_load = 1'b1;
				state_d = S_W_EDGE;
			end
			S_SCAN: begin
				priority if (sts.scan_done) begin
					cmd.set_res = 1'b1;
					state_d = S_EMIT1;
				end else if (sts.scan_visited) begin
					cmd.scan_inc = 1'b1;
				end else begin
					cmd.root_push = 1'b1;
					cmd.root_scan = 1'b1;
					cmd.scan_inc = 1'b1;
					state_d = S_LD_HEAD;
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

endmodule

// ===== rtl/core/graph_dfs_cycle_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_dfs_cycle_engine
// Adjacency-list graph store with depth-first walk and cycle check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command beat: func selects
//   add edge, depth-first walk or cycle check. One command is in work at a
//   time; in_ready is high only while the engine is idle.
//   Output channel (out_valid/out_ready) gives one beat per add or cycle
//   check and one beat per visited node for a walk; last_of_run marks the
//   final beat. A walk start at or above the node count gives one range beat.
//   Config channel (cfg_valid/cfg_ready) writes directed_mode, always ready;
//   write it only while idle.
//   Sequence: after the accepting edge an add dispatches, then runs a read,
//   write and link step per stored direction (one directed, two undirected)
//   and loads the result beat; in_ready returns in the cycle after the load.
//   A walk or check dispatches, reads each edge and takes it or pushes its
//   node and loads its head, reloads the frame per pop; a check scans roots.
//   A walk holds each node back one step so that the final beat is marked.
//   Reset clears all lists, counts and mode (directed). A stalled receiver
//   stops the engine where it next has a beat to load; no beat is dropped.
// ----------------------------------------------------------------------------
module graph_dfs_cycle_engine #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gdce_pkg::FUNC_W-1:0]   func,
	input  logic [gdce_pkg::NODE_W-1:0]   first_node,
	input  logic [gdce_pkg::NODE_W-1:0]   second_node,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gdce_pkg::STATUS_W-1:0] status,
	output logic [gdce_pkg::NODE_W-1:0]   visited_node,
	output logic                          last_of_run,
	output logic                          cycle_found,
	output logic                          is_tree_flag,
	output logic                          is_dag_flag,
	output logic [gdce_pkg::COUNT_W-1:0]  node_total,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data
);

	gdce_pkg::cmd_t cmd;
	gdce_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	// sequencer
	gdce_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sts(sts), .cmd(cmd)
	);

	// storage and result registers
	gdce_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.func(func), .first_node(first_node), .second_node(second_node),
		.cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.visited_node(visited_node), .last_of_run(last_of_run),
		.cycle_found(cycle_found), .is_tree_flag(is_tree_flag),
		.is_dag_flag(is_dag_flag), .node_total(node_total)
	);

endmodule

// ===== tb/sv/gdce_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdce_checker
// Watches the command, result and mode-write channels of the depth-first
// search engine, keeps its own copy of the graph store, predicts every
// result beat and compares each accepted beat with the oldest prediction.
// ----------------------------------------------------------------------------
module gdce_checker #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [gdce_pkg::FUNC_W-1:0]   func,
	input  logic [gdce_pkg::NODE_W-1:0]   first_node,
	input  logic [gdce_pkg::NODE_W-1:0]   second_node,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [gdce_pkg::STATUS_W-1:0] status,
	input  logic [gdce_pkg::NODE_W-1:0]   visited_node,
	input  logic                          last_of_run,
	input  logic                          cycle_found,
	input  logic                          is_tree_flag,
	input  logic                          is_dag_flag,
	input  logic [gdce_pkg::COUNT_W-1:0]  node_total,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic                          cfg_data,
	output int                            fail_count,
	output int                            pending,
	output int                            edges_now,
	output int                            nodes_now,
	output int                            beat_count
);

	typedef struct packed {
		gdce_pkg::status_t            st;
		logic [gdce_pkg::NODE_W-1:0]  vn;
		logic                         last;
		logic                         cyc;
		logic                         tree;
		logic                         dag;
		logic [gdce_pkg::COUNT_W-1:0] tot;
	} beat_t;

	beat_t beat_q[$];

	// shadow graph store
	logic directed;
	int   tgt [MAX_EDGES];
	int   link[MAX_EDGES];
	int   head[MAX_NODES];
	int   tail[MAX_NODES];
	int   used;
	int   ncount;
	bit   seen [MAX_NODES];
	bit   onstk[MAX_NODES];
	int   stk_node[MAX_NODES];
	int   stk_par [MAX_NODES];
	bit   stk_hasp[MAX_NODES];
	int   stk_cur [MAX_NODES];
	int   depth;

	assign pending   = beat_q.size();
	assign edges_now = used;
	assign nodes_now = ncount;

	function automatic beat_t mk(gdce_pkg::status_t st, int vn, bit last, bit cyc,
		bit tree, bit dag);
		beat_t b;
		b.st = st;
		b.vn = vn[gdce_pkg::NODE_W-1:0];
		b.last = last;
		b.cyc = cyc;
		b.tree = tree;
		b.dag = dag;
		b.tot = ncount[gdce_pkg::COUNT_W-1:0];
		return b;
	endfunction

	// append one predicted beat
	function automatic void queue_beat(beat_t b);
		beat_q = {beat_q, b};
	endfunction

	function automatic void link_edge(int u, int v);
		tgt[used] = v;
		link[used] = -1;
		if (tail[u] < 0) head[u] = used;
		else link[tail[u]] = used;
		tail[u] = used;
		used++;
	endfunction

	function automatic void push_frame(int n, bit hasp, int par);
		if (depth >= MAX_NODES) return;
		stk_node[depth] = n;
		stk_hasp[depth] = hasp;
		stk_par[depth] = par;
		stk_cur[depth] = head[n];
		depth++;
		seen[n] = 1;
		onstk[n] = 1;
	endfunction

	// search from one root for a closing edge
	function automatic bit closes_cycle(int root);
		int e, w, top;
		depth = 0;
		push_frame(root, 0, 0);
		while (depth > 0) begin
			top = depth - 1;
			e = stk_cur[top];
			if (e < 0) begin
				onstk[stk_node[top]] = 0;
				depth--;
				continue;
			end
			stk_cur[top] = link[e];
			w = tgt[e];
			if (directed && onstk[w]) return 1;
			if (!directed && seen[w] && !(stk_hasp[top] && stk_par[top] == w)) return 1;
			if (!seen[w]) push_frame(w, 1, stk_node[top]);
		end
		return 0;
	endfunction

	// expected beats for one accepted command
	function automatic void predict_command(gdce_pkg::func_t f, int a, int b);
		int need, hi, e, w, top, n;
		bit cyc;
		case (f)
			gdce_pkg::FUNC_ADD: begin
				need = directed ? 1 : 2;
				if (a >= MAX_NODES || b >= MAX_NODES) begin
					queue_beat(mk(gdce_pkg::ST_RANGE, 0, 1, 0, 0, 0));
				end else if (used + need > MAX_EDGES) begin
					queue_beat(mk(gdce_pkg::ST_FULL, 0, 1, 0, 0, 0));
				end else begin
					hi = ((a > b) ? a : b) + 1;
					if (hi > ncount) ncount = hi;
					link_edge(a, b);
					if (!directed) link_edge(b, a);
					queue_beat(mk(gdce_pkg::ST_OK, 0, 1, 0, 0, 0));
				end
			end
			gdce_pkg::FUNC_WALK: begin
				if (a >= ncount) begin
					queue_beat(mk(gdce_pkg::ST_RANGE, 0, 1, 0, 0, 0));
				end else begin
					for (int i = 0; i < MAX_NODES; i++) begin
						seen[i] = 0;
						onstk[i] = 0;
					end
					depth = 0;
					n = 0;
					push_frame(a, 0, 0);
					queue_beat(mk(gdce_pkg::ST_OK, a, 0, 0, 0, 0));
					n++;
					while (depth > 0) begin
						top = depth - 1;
						e = stk_cur[top];
						if (e < 0) begin
							depth--;
							continue;
						end
						stk_cur[top] = link[e];
						w = tgt[e];
						if (!seen[w] && n < MAX_NODES) begin
							push_frame(w, 1, stk_node[top]);
							queue_beat(mk(gdce_pkg::ST_OK, w, 0, 0, 0, 0));
							n++;
						end
					end
					beat_q[beat_q.size() - 1].last = 1'b1;
				end
			end
			gdce_pkg::FUNC_CYCLE: begin
				cyc = 0;
				for (int i = 0; i < MAX_NODES; i++) begin
					seen[i] = 0;
					onstk[i] = 0;
				end
				for (int i = 0; i < ncount && !cyc; i++)
					if (!seen[i]) cyc = closes_cycle(i);
				depth = 0;
				queue_beat(mk(gdce_pkg::ST_OK, 0, 1, cyc, !directed && !cyc,
					directed && !cyc));
			end
			default: ;
		endcase
	endfunction

	// watch the channels
	always @(posedge clk or negedge arst_n) begin
		beat_t exp_b, got;
		if (!arst_n) begin
			directed <= 1'b1;
			used = 0;
			ncount = 0;
			depth = 0;
			for (int i = 0; i < MAX_NODES; i++) begin
				head[i] = -1;
				tail[i] = -1;
			end
			beat_q.delete();
			fail_count <= 0;
			beat_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) directed <= cfg_data;
			if (in_valid && in_ready)
				predict_command(gdce_pkg::func_t'(func), int'(first_node),
					int'(second_node));
			if (out_valid && out_ready) begin
				beat_count <= beat_count + 1;
				got.st = gdce_pkg::status_t'(status);
				got.vn = visited_node;
				got.last = last_of_run;
				got.cyc = cycle_found;
				got.tree = is_tree_flag;
				got.dag = is_dag_flag;
				got.tot = node_total;
				if (beat_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result beat: st=%0d node=%0d last=%0b tot=%0d",
							got.st, got.vn, got.last, got.tot);
					fail_count <= fail_count + 1;
				end else begin
					exp_b = beat_q.pop_front();
					if (got !== exp_b) begin
						if (fail_count < 10)
							$display({"mismatch: exp st=%0d node=%0d last=%0b cyc=%0b tree=%0b ",
								"dag=%0b tot=%0d / got st=%0d node=%0d last=%0b cyc=%0b ",
								"tree=%0b dag=%0b tot=%0d"},
								exp_b.st, exp_b.vn, exp_b.last, exp_b.cyc, exp_b.tree,
								exp_b.dag, exp_b.tot, got.st, got.vn, got.last, got.cyc,
								got.tree, got.dag, got.tot);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives commands and mode writes into the depth-first search engine under
// random sender and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

	localparam int IDLE_LIMIT = 20000;
	localparam int RAND_ITEMS = 180;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [gdce_pkg::FUNC_W-1:0]   func;
	logic [gdce_pkg::NODE_W-1:0]   first_node;
	logic [gdce_pkg::NODE_W-1:0]   second_node;
	logic                          out_valid;
	logic                          out_ready;
	logic [gdce_pkg::STATUS_W-1:0] status;
	logic [gdce_pkg::NODE_W-1:0]   visited_node;
	logic                          last_of_run;
	logic                          cycle_found;
	logic                          is_tree_flag;
	logic                          is_dag_flag;
	logic [gdce_pkg::COUNT_W-1:0]  node_total;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic                          cfg_data;

	int fail_count, pending, edges_now, nodes_now, beat_count;
	int send_idle, recv_idle;
	int idle_cycles;
	int cmd_count;

	graph_dfs_cycle_engine u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .first_node(first_node), .second_node(second_node),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .visited_node(visited_node), .last_of_run(last_of_run),
		.cycle_found(cycle_found), .is_tree_flag(is_tree_flag),
		.is_dag_flag(is_dag_flag), .node_total(node_total),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	gdce_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .first_node(first_node), .second_node(second_node),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .visited_node(visited_node), .last_of_run(last_of_run),
		.cycle_found(cycle_found), .is_tree_flag(is_tree_flag),
		.is_dag_flag(is_dag_flag), .node_total(node_total),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .edges_now(edges_now),
		.nodes_now(nodes_now), .beat_count(beat_count)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver stalls
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// one command beat
	task automatic send_cmd(gdce_pkg::func_t f, int a, int b);
		@(negedge clk);
		in_valid = 1'b0;
		while ($urandom_range(99) < send_idle) @(negedge clk);
		in_valid = 1'b1;
		func = f;
		first_node = a[gdce_pkg::NODE_W-1:0];
		second_node = b[gdce_pkg::NODE_W-1:0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		cmd_count++;
	endtask

	// mode write, only once the engine has drained
	task automatic write_mode(bit m);
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int pick_node();
		if ($urandom_range(99) < 80) return $urandom_range(11);
		return $urandom_range(63);
	endfunction

	task automatic random_cmd();
		int r;
		r = $urandom_range(99);
		if (r < 45) send_cmd(gdce_pkg::FUNC_ADD, pick_node(), pick_node());
		else if (r < 72) begin
			if (nodes_now > 0 && $urandom_range(99) < 85)
				send_cmd(gdce_pkg::FUNC_WALK, $urandom_range(nodes_now - 1),
					$urandom_range(63));
			else
				send_cmd(gdce_pkg::FUNC_WALK, $urandom_range(63), $urandom_range(63));
		end else if (r < 95)
			send_cmd(gdce_pkg::FUNC_CYCLE, $urandom_range(63), $urandom_range(63));
		else send_cmd(gdce_pkg::FUNC_NONE, $urandom_range(63), $urandom_range(63));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = gdce_pkg::FUNC_ADD;
		first_node = '0;
		second_node = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b1;
		send_idle = 0;
		recv_idle = 0;
		cmd_count = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part: undirected cases first on an empty store
		write_mode(1'b0);
		send_cmd(gdce_pkg::FUNC_CYCLE, 0, 0);
		send_cmd(gdce_pkg::FUNC_WALK, 0, 0);
		send_cmd(gdce_pkg::FUNC_ADD, 0, 1);
		send_cmd(gdce_pkg::FUNC_ADD, 1, 0);
		send_cmd(gdce_pkg::FUNC_CYCLE, 0, 0);
		send_cmd(gdce_pkg::FUNC_WALK, 0, 0);
		send_cmd(gdce_pkg::FUNC_ADD, 1, 2);
		send_cmd(gdce_pkg::FUNC_WALK, 1, 63);
		send_cmd(gdce_pkg::FUNC_WALK, 10, 0);
		send_cmd(gdce_pkg::FUNC_NONE, 63, 63);
		send_cmd(gdce_pkg::FUNC_ADD, 5, 5);
		send_cmd(gdce_pkg::FUNC_CYCLE, 0, 0);
		// stored edges kept, rule switches to directed
		write_mode(1'b1);
		send_cmd(gdce_pkg::FUNC_CYCLE, 63, 63);
		send_cmd(gdce_pkg::FUNC_ADD, 63, 0);
		send_cmd(gdce_pkg::FUNC_ADD, 2, 62);
		send_cmd(gdce_pkg::FUNC_WALK, 63, 0);
		send_cmd(gdce_pkg::FUNC_WALK, 40, 0);
		send_cmd(gdce_pkg::FUNC_WALK, 62, 0);
		send_cmd(gdce_pkg::FUNC_CYCLE, 0, 0);

		// random part in three stall settings
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == 0) begin
				send_idle = 38;
				recv_idle = 60;
			end else if (i == RAND_ITEMS / 3) begin
				write_mode(1'b0);
				send_idle = 60;
				recv_idle = 38;
			end else if (i == 2 * RAND_ITEMS / 3) begin
				write_mode(1'b1);
				send_idle = 0;
				recv_idle = 0;
			end
			random_cmd();
		end

		// fill the edge table, then try further adds in both modes
		write_mode(1'b0);
		while (edges_now < 255)
			send_cmd(gdce_pkg::FUNC_ADD, pick_node(), pick_node());
		send_cmd(gdce_pkg::FUNC_ADD, 3, 9);
		send_cmd(gdce_pkg::FUNC_WALK, 0, 0);
		send_cmd(gdce_pkg::FUNC_CYCLE, 0, 0);
		write_mode(1'b1);
		send_cmd(gdce_pkg::FUNC_ADD, 63, 63);
		send_cmd(gdce_pkg::FUNC_WALK, 1, 0);
		send_cmd(gdce_pkg::FUNC_CYCLE, 0, 0);

		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);

		$display("run covered %0d commands and %0d result beats", cmd_count, beat_count);
		$display("both edge modes, table fill, range errors and three stall settings");
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== graph_dfs_cycle_engine.f =====
rtl/core/gdce_pkg.sv
rtl/core/gdce_ram.sv
rtl/core/gdce_dp.sv
rtl/core/gdce_ctrl.sv
rtl/core/graph_dfs_cycle_engine.sv
tb/sv/gdce_checker.sv
tb/sv/testbench.sv
